// ===== design/handle_slot_table_core_macros.svh =====
// Assertion macros used by the handle slot table back end (hst_back).
`ifndef HANDLE_SLOT_TABLE_CORE_MACROS_SVH
`define HANDLE_SLOT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define HST_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("handle slot table check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define HST_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("handle slot table check failed");

`endif

// ===== design/hst_pkg.sv =====
// Package: types, codes and sizes of the handle slot table.
`timescale 1ns / 1ps
package hst_pkg;

    localparam int SLOTS        = 256;
    localparam int WORD_BITS    = 32;
    localparam int ID_BITS      = 8;
    localparam int HANDLE_LIMIT = (SLOTS < 256) ? SLOTS : 256;
    localparam int SLOT_AW      = $clog2(SLOTS);
    localparam int GRP_BITS     = 16;
    localparam int GRPS         = SLOTS / GRP_BITS;
    localparam int GRP_AW       = $clog2(GRPS);
    localparam int BIT_AW       = $clog2(GRP_BITS);
    localparam int QDEPTH       = 2;
    localparam int QA_BITS      = $clog2(QDEPTH);
    localparam int QC_BITS      = $clog2(QDEPTH + 1);

    localparam logic [1:0] REQ_PUT = 2'd0;
    localparam logic [1:0] REQ_GET = 2'd1;
    localparam logic [1:0] REQ_EXT = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_GET,
        OP_EXT,
        OP_NULL,
        OP_BAD
    } t_op;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [ID_BITS-1:0]   slot_id;
        logic [31:0]          item_data;
    } t_in;

    typedef struct packed {
        logic [ID_BITS-1:0]   result_id;
        logic [31:0]          result_data;
        logic [1:0]           status;
        logic [ID_BITS-1:0]   item_count;
    } t_out;

    typedef struct packed {
        t_op                  op;
        logic [ID_BITS-1:0]   id;
        logic [WORD_BITS-1:0] word;
    } t_cmd;

endpackage

// ===== design/hst_fifo.sv =====
// Short command queue between the front classifier and the back sequencer.
`timescale 1ns / 1ps
module hst_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  hst_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output hst_pkg::t_cmd o_pop_cmd
);

    hst_pkg::t_cmd                  r_mem [hst_pkg::QDEPTH];
    logic [hst_pkg::QA_BITS-1:0]    r_wr_ptr;
    logic [hst_pkg::QA_BITS-1:0]    r_rd_ptr;
    logic [hst_pkg::QC_BITS-1:0]    r_cnt;
    logic [hst_pkg::QC_BITS-1:0]    n_cnt;
    logic                           w_push;
    logic                           w_pop;

    assign o_push_ready = (r_cnt != hst_pkg::QC_BITS'(hst_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid & o_push_ready;
    assign w_pop        = o_pop_valid & i_pop_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + hst_pkg::QC_BITS'(1);
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - hst_pkg::QC_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + hst_pkg::QA_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + hst_pkg::QA_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== design/hst_front.sv =====
// Front end: takes request beats and classifies them into queue commands.
`timescale 1ns / 1ps
module hst_front (
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hst_pkg::t_in  i_in_beat,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output hst_pkg::t_cmd o_push_cmd
);

    logic w_id_ok;
    logic w_null;

    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;

    assign w_id_ok = (i_in_beat.slot_id != '0) &&
                     ({1'b0, i_in_beat.slot_id} < (hst_pkg::ID_BITS + 1)'(hst_pkg::HANDLE_LIMIT));
    assign w_null  = (i_in_beat.item_data[hst_pkg::WORD_BITS-1:0] == '0);

    always_comb begin
        o_push_cmd.id   = i_in_beat.slot_id;
        o_push_cmd.word = i_in_beat.item_data[hst_pkg::WORD_BITS-1:0];
        unique case (i_in_beat.req_type)
            hst_pkg::REQ_PUT: begin
                o_push_cmd.op = w_null ? hst_pkg::OP_NULL : hst_pkg::OP_PUT;
            end
            hst_pkg::REQ_GET: begin
                o_push_cmd.op = w_id_ok ? hst_pkg::OP_GET : hst_pkg::OP_BAD;
            end
            hst_pkg::REQ_EXT: begin
                o_push_cmd.op = w_id_ok ? hst_pkg::OP_EXT : hst_pkg::OP_BAD;
            end
            default: begin
                o_push_cmd.op = hst_pkg::OP_BAD;
            end
        endcase
    end

endmodule

// ===== design/hst_back.sv =====
// Back end: slot memory, occupancy bitmap, free-slot search and result register.
`timescale 1ns / 1ps
`include "handle_slot_table_core_macros.svh"
module hst_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  hst_pkg::t_cmd i_pop_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hst_pkg::t_out o_out_beat
);

    hst_pkg::t_state                r_state;
    hst_pkg::t_state                n_state;
    hst_pkg::t_cmd                  r_cmd;
    logic [hst_pkg::WORD_BITS-1:0]  r_mem [hst_pkg::SLOTS];
    logic [hst_pkg::WORD_BITS-1:0]  r_rd_word;
    logic [hst_pkg::SLOT_AW-1:0]    w_rd_addr;
    logic [hst_pkg::SLOTS-1:0]      r_map;
    logic [hst_pkg::SLOTS-1:0]      w_view;
    logic [hst_pkg::GRPS-1:0]       w_grp_full;
    logic [hst_pkg::GRP_AW-1:0]     r_grp;
    logic [hst_pkg::GRP_AW-1:0]     n_grp;
    logic                           r_any;
    logic [hst_pkg::GRP_BITS-1:0]   w_grp_bits;
    logic [hst_pkg::BIT_AW-1:0]     w_bit;
    logic [hst_pkg::SLOT_AW-1:0]    w_slot;
    logic [hst_pkg::SLOT_AW-1:0]    w_cmd_addr;
    logic                           w_hit;
    logic                           w_take;
    logic                           w_done;
    logic                           w_set;
    logic                           w_clr;
    logic [hst_pkg::ID_BITS-1:0]    r_count;
    logic [hst_pkg::ID_BITS-1:0]    n_count;
    logic                           r_out_valid;
    hst_pkg::t_out                  r_out;
    hst_pkg::t_out                  n_out;

    // slot 0 never holds a handle: it reads as taken for the search
    always_comb begin
        w_view    = r_map;
        w_view[0] = 1'b1;
        for (int g = 0; g < hst_pkg::GRPS; g++) begin
            w_grp_full[g] = &w_view[g*hst_pkg::GRP_BITS +: hst_pkg::GRP_BITS];
        end
    end

    // lowest group with a free slot
    always_comb begin
        n_grp = '0;
        for (int g = hst_pkg::GRPS - 1; g >= 0; g--) begin
            if (!w_grp_full[g]) begin
                n_grp = hst_pkg::GRP_AW'(g);
            end
        end
    end

    // lowest free slot inside the chosen group
    always_comb begin
        w_grp_bits = w_view[r_grp*hst_pkg::GRP_BITS +: hst_pkg::GRP_BITS];
        w_bit      = '0;
        for (int b = hst_pkg::GRP_BITS - 1; b >= 0; b--) begin
            if (!w_grp_bits[b]) begin
                w_bit = hst_pkg::BIT_AW'(b);
            end
        end
    end

    assign w_slot      = {r_grp, w_bit};
    assign w_cmd_addr  = hst_pkg::SLOT_AW'(r_cmd.id);
    assign w_hit       = r_map[w_cmd_addr];
    assign w_done      = (r_state == hst_pkg::S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_pop_ready = (r_state == hst_pkg::S_IDLE);
    assign w_take      = i_pop_valid & o_pop_ready;
    assign w_rd_addr   = (r_state == hst_pkg::S_IDLE) ? hst_pkg::SLOT_AW'(i_pop_cmd.id)
                                                      : w_cmd_addr;
    assign w_set       = w_done && (r_cmd.op == hst_pkg::OP_PUT) && r_any;
    assign w_clr       = w_done && (r_cmd.op == hst_pkg::OP_EXT) && w_hit;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        n_count = r_count;
        if (w_set) begin
            n_count = r_count + hst_pkg::ID_BITS'(1);
        end else if (w_clr) begin
            n_count = r_count - hst_pkg::ID_BITS'(1);
        end
    end

    always_comb begin
        n_state            = r_state;
        n_out.result_id    = '0;
        n_out.result_data  = '0;
        n_out.status       = hst_pkg::ST_BAD;
        n_out.item_count   = n_count;
        unique case (r_state)
            hst_pkg::S_IDLE: begin
                if (w_take) begin
                    n_state = hst_pkg::S_EXEC;
                end
            end
            hst_pkg::S_EXEC: begin
                if (w_done) begin
                    n_state = hst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hst_pkg::S_IDLE;
            end
        endcase
        unique case (r_cmd.op) inside
            hst_pkg::OP_PUT: begin
                if (r_any) begin
                    n_out.result_id = hst_pkg::ID_BITS'(w_slot);
                    n_out.status    = hst_pkg::ST_OK;
                end else begin
                    n_out.status    = hst_pkg::ST_FULL;
                end
            end
            hst_pkg::OP_GET, hst_pkg::OP_EXT: begin
                if (w_hit) begin
                    n_out.result_id   = r_cmd.id;
                    n_out.result_data = 32'(r_rd_word);
                    n_out.status      = hst_pkg::ST_OK;
                end
            end
            hst_pkg::OP_NULL: begin
                n_out.status = hst_pkg::ST_NULL;
            end
            default: begin
                n_out.status = hst_pkg::ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hst_pkg::S_IDLE;
            r_map       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_set) begin
                r_map[w_slot] <= 1'b1;
            end else if (w_clr) begin
                r_map[w_cmd_addr] <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= i_pop_cmd;
            r_grp <= n_grp;
            r_any <= ~&w_grp_full;
        end
        if (w_done) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_set) begin
            r_mem[w_slot] <= r_cmd.word;
        end
        r_rd_word <= r_mem[w_rd_addr];
    end

    `HST_ASSERT_IMP(a_count_matches_map, 1'b1, $countones(r_map) == 32'(r_count))
    `HST_ASSERT_IMP(a_slot0_never_used, 1'b1, !r_map[0])
    `HST_ASSERT_NXT(a_put_marks_slot, w_set, r_map[$past(w_slot)])
    `HST_ASSERT_NXT(a_done_gives_beat, w_done, r_out_valid && (r_state == hst_pkg::S_IDLE))

endmodule

// ===== design/handle_slot_table_core.sv =====
// A request goes through the command queue and back sequencer into the output register.
// The back sequencer takes no new command until the last one is done: slot memory read
// with group search, then bitmap/memory update and result load, which waits while a held result is not taken.
// Up to 2 commands queue between front and back, so input keeps flowing under a short stall.
// Reset (synchronous, active low) empties the queue, clears the bitmap and count;
// slot memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module handle_slot_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hst_pkg::t_in  i_in_beat,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hst_pkg::t_out o_out_beat
);

    logic          w_push_valid;
    logic          w_push_ready;
    hst_pkg::t_cmd w_push_cmd;
    logic          w_pop_valid;
    logic          w_pop_ready;
    hst_pkg::t_cmd w_pop_cmd;

    hst_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_beat    (i_in_beat),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    hst_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    hst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (w_pop_valid),
        .o_pop_ready  (w_pop_ready),
        .i_pop_cmd    (w_pop_cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_beat   (o_out_beat)
    );

endmodule
